@@ design/qswtg_pkg.sv @@
// ----------------------------------------------------------------------------
// qswtg_pkg
// Shared types and constants of the queued square-wave tone generator.
// ----------------------------------------------------------------------------
package qswtg_pkg;

    localparam int SAMPLE_RATE_HZ = 44100;

    localparam int FREQ_W   = 24;
    localparam int MS_W     = 16;
    localparam int CNT_W    = 22;
    localparam int STEP_W   = 32;
    localparam int AMP_W    = 15;
    localparam int SAMPLE_W = 16;
    localparam int QCOUNT_W = 10;

    localparam logic [AMP_W-1:0] AMP_RESET = 15'd20000;

    // below 1.0 Hz in q16.8
    localparam int REST_LIMIT = 256;

    // step = freq * 2^24 / rate, split into integer and fractional parts
    localparam int     STEP_INT   = (1 << 24) / SAMPLE_RATE_HZ;
    localparam int     STEP_REM   = (1 << 24) % SAMPLE_RATE_HZ;
    localparam longint FREQ_MULT  = (longint'(STEP_REM) << 24) / SAMPLE_RATE_HZ;
    localparam int     FREQ_REM_W = $clog2(2 * SAMPLE_RATE_HZ);

    // samples = ms * rate / 1000, split the same way
    localparam int MS_PER_S = 1000;
    localparam int MS_INT   = SAMPLE_RATE_HZ / MS_PER_S;
    localparam int MS_REM   = SAMPLE_RATE_HZ % MS_PER_S;
    localparam int MS_MULT  = (MS_REM << MS_W) / MS_PER_S;
    localparam int MS_REM_W = $clog2(2 * MS_PER_S);

    typedef enum logic {
        FUNC_PUSH = 1'b0,
        FUNC_TICK = 1'b1
    } t_func;

    typedef struct packed {
        logic              rest;
        logic [STEP_W-1:0] step;
        logic [CNT_W-1:0]  tone;
        logic [CNT_W-1:0]  gap;
    } t_note;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef struct packed {
        logic pop;
        logic active_nxt;
    } t_tone_status;

endpackage

@@ design/qswtg_note_conv.sv @@
// ----------------------------------------------------------------------------
// qswtg_note_conv
// Converts a note request into phase step and sample counts: one registered
// multiply stage followed by a short remainder correction.
// ----------------------------------------------------------------------------
module qswtg_note_conv import qswtg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_load,
    input  logic [FREQ_W-1:0] i_freq,
    input  logic [MS_W-1:0]   i_tone_ms,
    input  logic [MS_W-1:0]   i_gap_ms,
    output t_note             o_note
);

    logic [FREQ_W-1:0]    r_freq;
    logic [MS_W-1:0]      r_tone_ms;
    logic [MS_W-1:0]      r_gap_ms;
    logic [FREQ_W+23:0]   r_freq_prod;
    logic [2*MS_W-1:0]    r_tone_prod;
    logic [2*MS_W-1:0]    r_gap_prod;

    logic [FREQ_W-1:0]     freq_est;
    logic [FREQ_REM_W-1:0] freq_rem;
    logic [FREQ_W-1:0]     freq_frac;

    function automatic logic [CNT_W-1:0] ms_fix(input logic [MS_W-1:0] ms,
                                                input logic [2*MS_W-1:0] prod);
        logic [MS_W-1:0]     est;
        logic [MS_REM_W-1:0] rem;
        logic [MS_W-1:0]     frac;
        est  = prod[2*MS_W-1:MS_W];
        rem  = MS_REM_W'(ms * MS_REM) - MS_REM_W'(est * MS_PER_S);
        frac = est + MS_W'(rem >= MS_REM_W'(MS_PER_S));
        return CNT_W'(ms * MS_INT) + CNT_W'(frac);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_freq      <= i_freq;
            r_tone_ms   <= i_tone_ms;
            r_gap_ms    <= i_gap_ms;
            r_freq_prod <= (FREQ_W+24)'(i_freq) * (FREQ_W+24)'(FREQ_MULT);
            r_tone_prod <= (2*MS_W)'(i_tone_ms) * (2*MS_W)'(MS_MULT);
            r_gap_prod  <= (2*MS_W)'(i_gap_ms) * (2*MS_W)'(MS_MULT);
        end
    end

    // estimate is exact or one low
    always_comb begin
        freq_est  = r_freq_prod[FREQ_W+23:24];
        freq_rem  = FREQ_REM_W'(r_freq * STEP_REM) - FREQ_REM_W'(freq_est * SAMPLE_RATE_HZ);
        freq_frac = freq_est + FREQ_W'(freq_rem >= FREQ_REM_W'(SAMPLE_RATE_HZ));
        o_note.rest = (r_freq < FREQ_W'(REST_LIMIT));
        o_note.step = STEP_W'(r_freq * STEP_INT) + STEP_W'(freq_frac);
        o_note.tone = ms_fix(r_tone_ms, r_tone_prod);
        o_note.gap  = ms_fix(r_gap_ms, r_gap_prod);
    end

endmodule

@@ design/qswtg_note_queue.sv @@
// ----------------------------------------------------------------------------
// qswtg_note_queue
// Note fifo on a single memory; the read is addressed by the next read
// pointer so the head entry is always registered and ready.
// ----------------------------------------------------------------------------
module qswtg_note_queue import qswtg_pkg::*; #(
    parameter int QUEUE_DEPTH = 1024,
    parameter int PTR_W       = $clog2(QUEUE_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_pop,
    input  t_note             i_wdata,
    output t_note             o_head,
    output t_queue_status     o_status,
    output logic [PTR_W-1:0]  o_count_nxt
);

    t_note             mem [QUEUE_DEPTH];
    t_note             r_head;
    t_note             r_fwd_data;
    logic              r_fwd;
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [PTR_W-1:0]  r_count;
    logic [PTR_W-1:0]  n_wr_ptr;
    logic [PTR_W-1:0]  n_rd_ptr;
    logic [PTR_W-1:0]  n_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_count = r_count + 1'b1;
        end else if (i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_fwd    <= 1'b0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
            r_fwd    <= i_push && (r_wr_ptr == n_rd_ptr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_wr_ptr] <= i_wdata;
        end
        r_head     <= mem[n_rd_ptr];
        r_fwd_data <= i_wdata;
    end

    assign o_head         = r_fwd ? r_fwd_data : r_head;
    assign o_status.full  = (r_count == PTR_W'(QUEUE_DEPTH - 1));
    assign o_status.empty = (r_count == '0);
    assign o_count_nxt    = n_count;

endmodule

@@ design/qswtg_tone_core.sv @@
// ----------------------------------------------------------------------------
// qswtg_tone_core
// Square-wave player: note timing, phase accumulator and sample level.
// ----------------------------------------------------------------------------
module qswtg_tone_core import qswtg_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  t_note                      i_head,
    input  logic                       i_empty,
    input  logic [AMP_W-1:0]           i_amp,
    output t_tone_status               o_status,
    output logic signed [SAMPLE_W-1:0] o_sample
);

    logic [STEP_W-1:0] r_phase;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_tone_left;
    logic [CNT_W-1:0]  r_gap_cnt;
    logic              r_in_gap;
    logic              r_active;
    logic              r_rest;

    logic [STEP_W-1:0] n_phase;
    logic [STEP_W-1:0] n_step;
    logic [CNT_W-1:0]  n_tone_left;
    logic [CNT_W-1:0]  n_gap_cnt;
    logic              n_in_gap;
    logic              n_active;
    logic              n_rest;

    logic              need_pop;
    logic              pop;
    logic [STEP_W-1:0] step_e;
    logic [CNT_W-1:0]  tone_e;
    logic [CNT_W-1:0]  gap_e;
    logic              rest_e;
    logic              in_gap_e;
    logic [SAMPLE_W-1:0] level;

    always_comb begin
        need_pop = !r_active || (r_tone_left == '0 && r_gap_cnt == '0);
        pop      = i_fire && need_pop && !i_empty;
        step_e   = pop ? i_head.step : r_step;
        tone_e   = pop ? i_head.tone : r_tone_left;
        gap_e    = pop ? i_head.gap  : r_gap_cnt;
        rest_e   = pop ? i_head.rest : r_rest;
        in_gap_e = pop ? (i_head.tone == '0 && i_head.gap != '0) : r_in_gap;
        level    = SAMPLE_W'(i_amp);
    end

    always_comb begin
        n_phase     = r_phase;
        n_step      = r_step;
        n_tone_left = r_tone_left;
        n_gap_cnt   = r_gap_cnt;
        n_in_gap    = r_in_gap;
        n_active    = r_active;
        n_rest      = r_rest;
        o_sample    = '0;
        if (i_fire) begin
            priority if (need_pop && i_empty) begin
                n_active = 1'b0;
            end else if (pop && i_head.tone == '0 && i_head.gap == '0) begin
                // empty note ends on the tick that pops it
                n_step      = step_e;
                n_rest      = rest_e;
                n_tone_left = '0;
                n_gap_cnt   = '0;
                n_in_gap    = 1'b0;
                n_active    = 1'b0;
            end else if (in_gap_e) begin
                n_step      = step_e;
                n_rest      = rest_e;
                n_tone_left = tone_e;
                n_gap_cnt   = gap_e - 1'b1;
                n_in_gap    = 1'b1;
                n_active    = (gap_e != CNT_W'(1));
            end else begin
                n_step      = step_e;
                n_rest      = rest_e;
                n_gap_cnt   = gap_e;
                n_tone_left = tone_e - 1'b1;
                n_in_gap    = 1'b0;
                n_active    = 1'b1;
                if (!rest_e) begin
                    o_sample = r_phase[STEP_W-1] ? -$signed(level) : $signed(level);
                    n_phase  = r_phase + step_e;
                end
                if (tone_e == CNT_W'(1)) begin
                    if (gap_e != '0) begin
                        n_in_gap = 1'b1;
                    end else begin
                        n_active = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_step      <= '0;
            r_tone_left <= '0;
            r_gap_cnt   <= '0;
            r_in_gap    <= 1'b0;
            r_active    <= 1'b0;
            r_rest      <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_step      <= n_step;
            r_tone_left <= n_tone_left;
            r_gap_cnt   <= n_gap_cnt;
            r_in_gap    <= n_in_gap;
            r_active    <= n_active;
            r_rest      <= n_rest;
        end
    end

    assign o_status.pop        = pop;
    assign o_status.active_nxt = n_active;

endmodule

@@ design/queued_square_wave_tone_generator.sv @@
// ----------------------------------------------------------------------------
// queued_square_wave_tone_generator
// Note queue feeding a square-wave tone player, one request per cycle while results are taken.
//
//   channel  direction  handshake           payload
//   request  in         i_valid / o_ready   i_func, i_freq_q8, i_tone_ms, i_gap_ms
//   result   out        o_valid / i_ready   o_sample, o_accepted, o_queue_count,
//                                           o_busy_res
//   config   in         i_cfg_we            i_cfg_wdata (amplitude)
//
// one request per cycle sustained while i_ready holds; the result passes through
// the input register, conversion multiply register and result register
// the note memory read is registered at the next read pointer, so a pop
// every cycle is served without a wait
// synchronous reset clears pointers, count and tone state; memory is not cleared
// a stalled result holds in the output register; empty stages still fill
// ----------------------------------------------------------------------------
module queued_square_wave_tone_generator import qswtg_pkg::*; #(
    parameter int QUEUE_DEPTH = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_func,
    input  logic [FREQ_W-1:0]          i_freq_q8,
    input  logic [MS_W-1:0]            i_tone_ms,
    input  logic [MS_W-1:0]            i_gap_ms,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [SAMPLE_W-1:0] o_sample,
    output logic                       o_accepted,
    output logic [QCOUNT_W-1:0]        o_queue_count,
    output logic                       o_busy_res,
    input  logic                       i_cfg_we,
    input  logic [AMP_W-1:0]           i_cfg_wdata
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int WIDE_W = (PTR_W > QCOUNT_W) ? PTR_W : QCOUNT_W;

    logic                r_s0_valid;
    t_func               r_s0_func;
    logic [FREQ_W-1:0]   r_s0_freq;
    logic [MS_W-1:0]     r_s0_tone;
    logic [MS_W-1:0]     r_s0_gap;
    logic                r_s1_valid;
    t_func               r_s1_func;
    logic                r_out_valid;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                r_accepted;
    logic [QCOUNT_W-1:0] r_queue_count;
    logic                r_busy;
    logic [AMP_W-1:0]    r_amp;

    logic                ld_out;
    logic                s1_free;
    logic                s0_go;
    logic                s0_free;
    logic                in_fire;
    logic                exec;
    logic                exec_tick;
    logic                push_ok;
    t_note               conv_note;
    t_note               head;
    t_queue_status       q_status;
    t_tone_status        t_status;
    logic [PTR_W-1:0]    count_nxt;
    logic [WIDE_W-1:0]   count_wide;
    logic signed [SAMPLE_W-1:0] core_sample;

    always_comb begin
        ld_out    = !r_out_valid || i_ready;
        exec      = r_s1_valid && ld_out;
        s1_free   = !r_s1_valid || ld_out;
        s0_go     = r_s0_valid && s1_free;
        s0_free   = !r_s0_valid || s1_free;
        in_fire   = i_valid && s0_free;
        exec_tick = exec && (r_s1_func == FUNC_TICK);
        push_ok   = exec && (r_s1_func == FUNC_PUSH) && !q_status.full;
        count_wide = WIDE_W'(count_nxt);
    end

    qswtg_note_conv u_conv (
        .i_clk     (i_clk),
        .i_load    (s0_go),
        .i_freq    (r_s0_freq),
        .i_tone_ms (r_s0_tone),
        .i_gap_ms  (r_s0_gap),
        .o_note    (conv_note)
    );

    qswtg_note_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PTR_W       (PTR_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push_ok),
        .i_pop       (t_status.pop),
        .i_wdata     (conv_note),
        .o_head      (head),
        .o_status    (q_status),
        .o_count_nxt (count_nxt)
    );

    qswtg_tone_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (exec_tick),
        .i_head   (head),
        .i_empty  (q_status.empty),
        .i_amp    (r_amp),
        .o_status (t_status),
        .o_sample (core_sample)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_amp       <= AMP_RESET;
        end else begin
            r_s0_valid  <= in_fire || (r_s0_valid && !s1_free);
            r_s1_valid  <= s0_go || (r_s1_valid && !ld_out);
            r_out_valid <= exec || (r_out_valid && !i_ready);
            if (i_cfg_we) begin
                r_amp <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s0_func <= t_func'(i_func);
            r_s0_freq <= i_freq_q8;
            r_s0_tone <= i_tone_ms;
            r_s0_gap  <= i_gap_ms;
        end
        if (s0_go) begin
            r_s1_func <= r_s0_func;
        end
        if (exec) begin
            r_sample      <= exec_tick ? core_sample : '0;
            r_accepted    <= push_ok;
            r_queue_count <= count_wide[QCOUNT_W-1:0];
            r_busy        <= (count_nxt != '0) || t_status.active_nxt;
        end
    end

    assign o_ready       = s0_free;
    assign o_valid       = r_out_valid;
    assign o_sample      = r_sample;
    assign o_accepted    = r_accepted;
    assign o_queue_count = r_queue_count;
    assign o_busy_res    = r_busy;

endmodule
